// File: hdl/hsc_pkg.sv
// Shared types, codes and constant functions for the SEC-DED Hamming codec.
// Used by hsc_core, hamming_secded_codec_top, hsc_checker and the testbench; depends on nothing else.

package hsc_pkg;

    // Field widths
    localparam int DATA_W   = 57;
    localparam int CODE_W   = 64;
    localparam int SYN_W    = 6;
    localparam int STATUS_W = 2;
    localparam int K_W      = 6;
    localparam int R_W      = 3;
    localparam int CFG_IDX_W = 1;

    // Operation codes
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CORRECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PARITY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNCORR    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_PARITY = 1'b1;

    // Reset values of the configuration registers
    localparam logic [K_W-1:0] DATA_BITS_RST = 6'd57;
    localparam logic           EXT_PARITY_RST = 1'b1;

    // Code geometry handed to the datapath
    typedef struct packed {
        logic [K_W-1:0] k;    // information bits in use, 1..57
        logic [K_W-1:0] n;    // code length without the overall parity bit
        logic           ext;  // overall parity bit present
    } code_cfg_t;

    // Check-bit count for k information bits
    function automatic logic [R_W-1:0] check_count(input logic [K_W-1:0] k);
        logic [R_W-1:0] r;
        if (k <= 6'd1)       r = 3'd2;
        else if (k <= 6'd4)  r = 3'd3;
        else if (k <= 6'd11) r = 3'd4;
        else if (k <= 6'd26) r = 3'd5;
        else                 r = 3'd6;
        return r;
    endfunction

    // Codeword bit that carries information bit j (skips power-of-two positions)
    function automatic logic [SYN_W-1:0] data_pos(input int unsigned j);
        int unsigned p;
        int unsigned cnt;
        logic [SYN_W-1:0] res;
        cnt = 0;
        res = '0;
        for (p = 1; p < CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == j) res = SYN_W'(p - 1);
                cnt++;
            end
        end
        return res;
    endfunction

    // Codeword bits (positions 1..63) whose position has syndrome bit b set
    function automatic logic [CODE_W-2:0] syn_sel(input int unsigned b);
        logic [CODE_W-2:0] sel;
        int unsigned p;
        sel = '0;
        for (p = 1; p < CODE_W; p++) begin
            sel[p - 1] = ((p >> b) & 1) != 0;
        end
        return sel;
    endfunction

endpackage

// File: hdl/hsc_core.sv
// Combinational encode / check-and-correct datapath of the SEC-DED codec.
// Depends on hsc_pkg for widths, codes and the position tables.

module hsc_core
(
    input  hsc_pkg::code_cfg_t                cfg,
    input  logic                              action,
    input  logic [hsc_pkg::DATA_W-1:0]        data_word,
    input  logic [hsc_pkg::CODE_W-1:0]        received_word,
    output logic [hsc_pkg::CODE_W-1:0]        codeword,
    output logic [hsc_pkg::SYN_W-1:0]         syndrome,
    output logic [hsc_pkg::STATUS_W-1:0]      status
);

    logic [hsc_pkg::DATA_W-1:0] dmask;
    logic [hsc_pkg::DATA_W-1:0] dat;
    logic [hsc_pkg::CODE_W-1:0] nmask;
    logic [hsc_pkg::CODE_W-1:0] lmask;
    logic [hsc_pkg::CODE_W-1:0] bit_n;
    logic [hsc_pkg::SYN_W:0]    len;
    logic [hsc_pkg::CODE_W-1:0] scat;
    logic [hsc_pkg::CODE_W-1:0] chk;
    logic [hsc_pkg::CODE_W-1:0] enc_w;
    logic [hsc_pkg::SYN_W-1:0]  syn_e;
    logic [hsc_pkg::CODE_W-1:0] dec_w;
    logic [hsc_pkg::CODE_W-1:0] dec_n;
    logic [hsc_pkg::CODE_W-1:0] fixed_w;
    logic [hsc_pkg::SYN_W-1:0]  syn_d;
    logic                       par;
    logic [hsc_pkg::STATUS_W-1:0] st_d;

    // Length masks: k data bits, n code bits, n(+1) transmitted bits
    assign len   = {1'b0, cfg.n} + {{hsc_pkg::SYN_W{1'b0}}, cfg.ext};
    assign dmask = (hsc_pkg::DATA_W'(1) << cfg.k) - hsc_pkg::DATA_W'(1);
    assign nmask = (hsc_pkg::CODE_W'(1) << cfg.n) - hsc_pkg::CODE_W'(1);
    assign lmask = (hsc_pkg::CODE_W'(1) << len) - hsc_pkg::CODE_W'(1);
    assign bit_n = hsc_pkg::CODE_W'(1) << cfg.n;
    assign dat   = data_word & dmask;

    // Encode: scatter data, XOR-tree syndrome gives check bits, then parity
    always_comb
    begin
        scat = '0;
        for (int j = 0; j < hsc_pkg::DATA_W; j++)
        begin
            scat[hsc_pkg::data_pos(j)] = dat[j];
        end
        for (int b = 0; b < hsc_pkg::SYN_W; b++)
        begin
            syn_e[b] = ^(scat[hsc_pkg::CODE_W-2:0] & hsc_pkg::syn_sel(b));
        end
        chk = '0;
        for (int i = 0; i < hsc_pkg::SYN_W; i++)
        begin
            chk[hsc_pkg::SYN_W'((32'd1 << i) - 32'd1)] = syn_e[i];
        end
        enc_w = scat | chk;
        if (cfg.ext && (^enc_w))
        begin
            enc_w = enc_w | bit_n;
        end
    end

    // Decode: syndrome over n bits, overall parity over n+1 bits
    always_comb
    begin
        dec_w = received_word & lmask;
        dec_n = dec_w & nmask;
        for (int b = 0; b < hsc_pkg::SYN_W; b++)
        begin
            syn_d[b] = ^(dec_n[hsc_pkg::CODE_W-2:0] & hsc_pkg::syn_sel(b));
        end
        par = cfg.ext ? (^dec_w) : 1'b1;
    end

    // Correction and status
    always_comb
    begin
        fixed_w = dec_w;
        st_d    = hsc_pkg::ST_NONE;
        if (syn_d == '0)
        begin
            if (cfg.ext && par)
            begin
                fixed_w = dec_w ^ bit_n;
                st_d    = hsc_pkg::ST_PARITY;
            end
        end
        else if (cfg.ext && !par)
        begin
            st_d = hsc_pkg::ST_UNCORR;        // double error
        end
        else if (syn_d > cfg.n)
        begin
            st_d = hsc_pkg::ST_UNCORR;        // points past the code
        end
        else
        begin
            fixed_w = dec_w ^ (hsc_pkg::CODE_W'(1) << (syn_d - hsc_pkg::SYN_W'(1)));
            st_d    = hsc_pkg::ST_CORRECTED;
        end
    end

    // Result select
    always_comb
    begin
        if (action == hsc_pkg::ACT_DECODE)
        begin
            codeword = fixed_w & lmask;
            syndrome = syn_d;
            status   = st_d;
        end
        else
        begin
            codeword = enc_w & lmask;
            syndrome = '0;
            status   = hsc_pkg::ST_NONE;
        end
    end

endmodule

// File: hdl/hamming_secded_codec_top.sv
// Top level of the SEC-DED Hamming codec: config registers, input and result registers.
// Depends on hsc_pkg and hsc_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per word: action selects
//   encode (data_word) or decode (received_word). Output channel (out_valid /
//   out_stall) returns one beat per input beat, in order: codeword, syndrome, status.
//   A beat taken into the input register passes the XOR-tree datapath and lands in the
//   result register once that register is free, where out_valid shows it. Throughput
//   is one word per cycle while the receiver does not stall; the single-pass XOR logic
//   between the two registers sets that figure.
//   When the receiver stalls, the result register holds its beat and the input
//   register still takes one more beat; in_stall rises only when both are full.
//   Config port: cfg_we with cfg_index 0 writes data_bits (6 bits), index 1 writes
//   extended_parity (cfg_data bit 0). Write only while no beat is in flight.
//   data_bits of 0 acts as 1; above MAX_DATA_BITS acts as MAX_DATA_BITS.
//   Reset empties both registers and sets data_bits = 57, extended_parity = 1.

module hamming_secded_codec_top
#(
    parameter int MAX_DATA_BITS = 57
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hsc_pkg::K_W-1:0]             cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [MAX_DATA_BITS-1:0]            data_word,
    input  logic [hsc_pkg::CODE_W-1:0]          received_word,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hsc_pkg::CODE_W-1:0]          codeword,
    output logic [hsc_pkg::SYN_W-1:0]           syndrome,
    output logic [hsc_pkg::STATUS_W-1:0]        status
);

    logic [hsc_pkg::K_W-1:0]      data_bits_reg;
    logic                         ext_parity_reg;
    logic                         s1_valid_reg;
    logic                         s1_action_reg;
    logic [hsc_pkg::DATA_W-1:0]   s1_data_reg;
    logic [hsc_pkg::CODE_W-1:0]   s1_recv_reg;
    logic                         out_valid_reg;
    logic [hsc_pkg::CODE_W-1:0]   codeword_reg;
    logic [hsc_pkg::SYN_W-1:0]    syndrome_reg;
    logic [hsc_pkg::STATUS_W-1:0] status_reg;
    logic [hsc_pkg::CODE_W-1:0]   codeword_next;
    logic [hsc_pkg::SYN_W-1:0]    syndrome_next;
    logic [hsc_pkg::STATUS_W-1:0] status_next;
    logic [hsc_pkg::K_W-1:0]      k_eff;
    hsc_pkg::code_cfg_t           code_cfg;
    logic                         out_open;
    logic                         s1_move;
    logic                         in_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bits_reg  <= hsc_pkg::DATA_BITS_RST;
            ext_parity_reg <= hsc_pkg::EXT_PARITY_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hsc_pkg::REG_DATA_BITS)
            begin
                data_bits_reg <= cfg_data;
            end
            if (cfg_index == hsc_pkg::REG_EXT_PARITY)
            begin
                ext_parity_reg <= cfg_data[0];
            end
        end
    end

    // Effective code geometry
    always_comb
    begin
        if (data_bits_reg == '0)
            k_eff = hsc_pkg::K_W'(1);
        else if (data_bits_reg > hsc_pkg::K_W'(MAX_DATA_BITS))
            k_eff = hsc_pkg::K_W'(MAX_DATA_BITS);
        else
            k_eff = data_bits_reg;
        code_cfg.k   = k_eff;
        code_cfg.n   = k_eff + hsc_pkg::K_W'(hsc_pkg::check_count(k_eff));
        code_cfg.ext = ext_parity_reg;
    end

    // Handshake: result register frees when empty or taken
    assign out_open = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_open;
    assign in_stall = s1_valid_reg && !out_open;
    assign in_take  = in_valid && !in_stall;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take || s1_move)
                s1_valid_reg <= in_take;
            if (out_open)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_action_reg <= action;
            s1_data_reg   <= hsc_pkg::DATA_W'(data_word);
            s1_recv_reg   <= received_word;
        end
    end

    hsc_core u_core
    (
        .cfg           (code_cfg),
        .action        (s1_action_reg),
        .data_word     (s1_data_reg),
        .received_word (s1_recv_reg),
        .codeword      (codeword_next),
        .syndrome      (syndrome_next),
        .status        (status_next)
    );

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            codeword_reg <= codeword_next;
            syndrome_reg <= syndrome_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign codeword  = codeword_reg;
    assign syndrome  = syndrome_reg;
    assign status    = status_reg;

    // Checks
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled while a register is free");

    a_hold_both: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> (s1_valid_reg && out_valid_reg))
        else $error("beat lost during output stall");

    a_none_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == hsc_pkg::ST_NONE)) |-> (syndrome_reg == '0))
        else $error("clean status with nonzero syndrome");

    a_parity_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == hsc_pkg::ST_PARITY))
            |-> ((syndrome_reg == '0) && ext_parity_reg))
        else $error("parity-bit error reported without overall parity");

endmodule

// File: verif/hsc_checker.sv
// Scoreboard for the SEC-DED Hamming codec: watches the config port and both channels,
// predicts every result beat and compares it field by field.
// Depends on hsc_pkg.

module hsc_checker
    import hsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [K_W-1:0]       cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 action,
    input  logic [DATA_W-1:0]    data_word,
    input  logic [CODE_W-1:0]    received_word,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [CODE_W-1:0]    codeword,
    input  logic [SYN_W-1:0]     syndrome,
    input  logic [STATUS_W-1:0]  status,
    output int unsigned          mismatch_count,
    output int unsigned          words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CODE_W-1:0]   cw;
        logic [SYN_W-1:0]    syn;
        logic [STATUS_W-1:0] st;
    } codec_result_t;

    // Shadow copy of the code settings
    logic [K_W-1:0] k_setting;
    logic           ext_setting;

    codec_result_t  expected_words[$];
    int unsigned    err_total;

    // XOR of the positions (1..n) of all set bits, cut to r bits
    function automatic logic [SYN_W-1:0] pos_syndrome(logic [CODE_W-1:0] w, int unsigned n,
                                                      int unsigned r);
        logic [SYN_W-1:0] s;
        int unsigned      p;
        s = '0;
        for (p = 1; p <= n; p++)
        begin
            if (w[p-1])
                s = s ^ SYN_W'(p);
        end
        return s & SYN_W'((1 << r) - 1);
    endfunction

    // Expected result beat for one input beat under the given settings
    function automatic codec_result_t secded_result(logic act, logic [DATA_W-1:0] dw,
                                                    logic [CODE_W-1:0] rw,
                                                    logic [K_W-1:0] k_reg, logic ext);
        int unsigned       k;
        int unsigned       r;
        int unsigned       n;
        int unsigned       len;
        int unsigned       j;
        int unsigned       p;
        logic [CODE_W-1:0] w;
        logic [CODE_W-1:0] mask;
        logic [SYN_W-1:0]  s;
        logic              par;
        codec_result_t     res;

        k = k_reg;
        if (k < 1)
            k = 1;
        if (k > DATA_W)
            k = DATA_W;
        if (k <= 1)
            r = 2;
        else if (k <= 4)
            r = 3;
        else if (k <= 11)
            r = 4;
        else if (k <= 26)
            r = 5;
        else
            r = 6;
        n    = k + r;
        len  = n + ext;
        mask = (len >= CODE_W) ? '1 : ((64'd1 << len) - 64'd1);
        w       = '0;
        res.syn = '0;
        res.st  = ST_NONE;

        if (act == ACT_ENCODE)
        begin
            // data bits go to the non-power-of-two positions, lowest first
            j = 0;
            for (p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    w[p-1] = dw[j];
                    j++;
                end
            end
            s = pos_syndrome(w, n, r);
            for (j = 0; j < r; j++)
            begin
                if (s[j])
                    w[(1 << j) - 1] = 1'b1;
            end
            if (ext)
                w[n] = ^w;
        end
        else
        begin
            w       = rw & mask;
            s       = pos_syndrome(w, n, r);
            par     = ext ? ^w : 1'b1;
            res.syn = s;
            if (s == 0)
            begin
                if (ext && par)
                begin
                    w[n]   = ~w[n];
                    res.st = ST_PARITY;
                end
            end
            else if (ext && !par)
                res.st = ST_UNCORR;
            else if (s > n)
                res.st = ST_UNCORR;
            else
            begin
                w[s-1] = ~w[s-1];
                res.st = ST_CORRECTED;
            end
        end
        res.cw = w & mask;
        return res;
    endfunction

    // Track settings, queue predictions on input beats, check result beats
    always @(posedge clk or negedge rst_n)
    begin
        codec_result_t exp_beat;
        if (!rst_n)
        begin
            k_setting   = DATA_BITS_RST;
            ext_setting = EXT_PARITY_RST;
            expected_words.delete();
            err_total   = 0;
            mismatch_count  <= 0;
            words_in_flight <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DATA_BITS)
                    k_setting = cfg_data;
                else if (cfg_index == REG_EXT_PARITY)
                    ext_setting = cfg_data[0];
            end

            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result beat with nothing expected: codeword %h", codeword);
                    err_total++;
                end
                else
                begin
                    exp_beat = expected_words.pop_front();
                    if (codeword !== exp_beat.cw)
                    begin
                        $error("codeword: expected %h, actual %h", exp_beat.cw, codeword);
                        err_total++;
                    end
                    if (syndrome !== exp_beat.syn)
                    begin
                        $error("syndrome: expected %0d, actual %0d", exp_beat.syn, syndrome);
                        err_total++;
                    end
                    if (status !== exp_beat.st)
                    begin
                        $error("status: expected %0d, actual %0d", exp_beat.st, status);
                        err_total++;
                    end
                end
            end

            if (in_valid && !in_stall)
                expected_words.push_back(secded_result(action, data_word, received_word,
                                                       k_setting, ext_setting));

            mismatch_count  <= err_total;
            words_in_flight <= expected_words.size();
        end
    end

endmodule

// File: verif/tb_hamming_secded_codec_top.sv
// Testbench top for hamming_secded_codec_top: clock, reset, config writes and
// randomized encode/decode traffic with random gaps and stalls; hsc_checker does the checking.
// Depends on hsc_pkg, hamming_secded_codec_top and hsc_checker.

module tb_hamming_secded_codec_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsc_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [K_W-1:0]      cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                action;
    logic [DATA_W-1:0]   data_word;
    logic [CODE_W-1:0]   received_word;
    logic                out_valid;
    logic                out_stall;
    logic [CODE_W-1:0]   codeword;
    logic [SYN_W-1:0]    syndrome;
    logic [STATUS_W-1:0] status;
    int unsigned         mismatch_count;
    int unsigned         words_in_flight;

    // Current code geometry as seen by the stimulus
    int unsigned cur_n;
    bit          cur_ext;
    bit          tx_burst;
    bit          rx_burst;
    int unsigned n_encode;
    int unsigned n_decode;
    int unsigned n_settings;

    hamming_secded_codec_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .data_word     (data_word),
        .received_word (received_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .codeword      (codeword),
        .syndrome      (syndrome),
        .status        (status)
    );

    hsc_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .data_word       (data_word),
        .received_word   (received_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .codeword        (codeword),
        .syndrome        (syndrome),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Code length n for a data_bits setting: smallest r with 2^r >= k + r + 1
    function automatic int unsigned code_len(logic [K_W-1:0] bits);
        int unsigned k;
        int unsigned r;
        k = bits;
        if (k < 1)
            k = 1;
        if (k > DATA_W)
            k = DATA_W;
        r = 2;
        while ((1 << r) < k + r + 1)
            r++;
        return k + r;
    endfunction

    // Random valid codeword: random bits in 1..n, check bits fixed up to zero the syndrome
    function automatic logic [CODE_W-1:0] valid_codeword(int unsigned n, bit ext);
        logic [CODE_W-1:0] w;
        logic [SYN_W-1:0]  s;
        int unsigned       p;
        w = {$urandom, $urandom};
        w = w & ((64'd1 << n) - 64'd1);
        s = '0;
        for (p = 1; p <= n; p++)
        begin
            if (w[p-1])
                s = s ^ SYN_W'(p);
        end
        for (p = 0; p < SYN_W; p++)
        begin
            if (s[p])
                w[(1 << p) - 1] = ~w[(1 << p) - 1];
        end
        if (ext)
            w[n] = ^w;
        return w;
    endfunction

    // Received word: mostly codewords with zero, one or two flips, some junk above
    // the code length, some pure noise
    function automatic logic [CODE_W-1:0] decode_stim(int unsigned n, bit ext);
        int unsigned       len;
        int unsigned       kind;
        int unsigned       a;
        int unsigned       b;
        logic [CODE_W-1:0] w;
        len  = n + ext;
        w    = valid_codeword(n, ext);
        kind = $urandom_range(0, 99);
        a    = $urandom_range(0, len - 1);
        b    = (a + $urandom_range(1, len - 1)) % len;
        if (kind >= 82)
            w = {$urandom, $urandom};
        else if (kind >= 70)
        begin
            if (kind % 2)
                w[a] = ~w[a];
            if (len < CODE_W)
                w = w | ({$urandom, $urandom} << len);
        end
        else if (kind >= 55)
        begin
            w[a] = ~w[a];
            w[b] = ~w[b];
        end
        else if (kind >= 25)
            w[a] = ~w[a];
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] encode_stim();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '1;
        else if (sel == 1)
            return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
        return DATA_W'({$urandom, $urandom});
    endfunction

    // One input beat, after a random gap unless bursting
    task automatic send_beat(input logic act, input logic [DATA_W-1:0] dw,
                             input logic [CODE_W-1:0] rw);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        data_word     <= dw;
        received_word <= rw;
        do
            @(posedge clk);
        while (in_stall);
        if (act == ACT_ENCODE)
            n_encode++;
        else
            n_decode++;
    endtask

    // Hold off input until every expected result beat has come back
    task automatic wait_drained();
        int unsigned guard;
        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (words_in_flight != 0 && guard < 2000);
    endtask

    task automatic set_code(input logic [K_W-1:0] bits, input logic ext);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DATA_BITS;
        cfg_data  <= bits;
        @(posedge clk);
        cfg_index <= REG_EXT_PARITY;
        cfg_data  <= K_W'(ext);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_n   = code_len(bits);
        cur_ext = ext;
        n_settings++;
    endtask

    // Receiver: a random stall before each result beat, unless bursting
    initial
    begin
        int unsigned hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_burst ? 0 : $urandom_range(0, 10);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Stimulus
    initial
    begin
        int unsigned       bits_tab[12] = '{57, 1, 0, 63, 2, 4, 5, 11, 12, 26, 27, 58};
        bit                ext_tab[12]  = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1};
        logic [CODE_W-1:0] cw;
        logic [K_W-1:0]    bits;
        bit                ext;
        int unsigned       ph;
        int unsigned       i;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_DATA_BITS;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        action        <= ACT_ENCODE;
        data_word     <= '0;
        received_word <= '0;
        tx_burst   = 1'b0;
        rx_burst   = 1'b0;
        n_encode   = 0;
        n_decode   = 0;
        n_settings = 1;
        cur_n      = code_len(DATA_BITS_RST);
        cur_ext    = EXT_PARITY_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset geometry (57 data bits, overall parity on)
        send_beat(ACT_ENCODE, '0, '0);
        send_beat(ACT_ENCODE, '1, '1);
        send_beat(ACT_ENCODE, DATA_W'(1), '0);
        send_beat(ACT_ENCODE, DATA_W'(1) << (DATA_W - 1), '0);
        send_beat(ACT_DECODE, '0, '0);
        send_beat(ACT_DECODE, '0, '1);
        cw = valid_codeword(cur_n, cur_ext);
        send_beat(ACT_DECODE, '1, cw);
        send_beat(ACT_DECODE, '0, cw ^ 64'd1);
        send_beat(ACT_DECODE, '0, cw ^ (64'd1 << 62));
        // flip of the overall parity bit only
        send_beat(ACT_DECODE, '0, cw ^ (64'd1 << 63));
        // double error
        send_beat(ACT_DECODE, '0, cw ^ 64'h3);

        // 2 data bits, no parity: positions 3 and 4 give a syndrome past n
        wait_drained();
        set_code(6'd2, 1'b0);
        send_beat(ACT_DECODE, '0, 64'hC);
        send_beat(ACT_DECODE, '0, '1);
        send_beat(ACT_ENCODE, '1, '0);

        // data_bits 0 behaves as 1
        wait_drained();
        set_code(6'd0, 1'b1);
        send_beat(ACT_ENCODE, '1, '0);
        cw = valid_codeword(cur_n, cur_ext);
        send_beat(ACT_DECODE, '0, cw ^ 64'h4);

        // data_bits above the maximum behaves as the maximum
        wait_drained();
        set_code(6'd63, 1'b0);
        send_beat(ACT_DECODE, '0, valid_codeword(cur_n, cur_ext) ^ (64'd1 << 62));
        send_beat(ACT_ENCODE, '1, '0);

        // Random phases, one code setting each
        for (ph = 0; ph < 16; ph++)
        begin
            if (ph < 12)
            begin
                bits = K_W'(bits_tab[ph]);
                ext  = ext_tab[ph];
            end
            else
            begin
                bits = K_W'($urandom_range(0, 63));
                ext  = $urandom_range(0, 1);
            end
            wait_drained();
            set_code(bits, ext);
            tx_burst = (ph % 4 == 3) || (ph % 5 == 1);
            rx_burst = (ph % 4 == 3) || (ph % 5 == 2);
            for (i = 0; i < 120; i++)
            begin
                if (i == 60 && ph % 3 == 0)
                    wait_drained();
                if ($urandom_range(0, 99) < 40)
                    send_beat(ACT_ENCODE, encode_stim(), {$urandom, $urandom});
                else
                    send_beat(ACT_DECODE, DATA_W'({$urandom, $urandom}),
                              decode_stim(cur_n, cur_ext));
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (words_in_flight != 0)
            $error("%0d expected result beats never arrived", words_in_flight);
        $display("Covered %0d encode and %0d decode beats over %0d code settings,",
                 n_encode, n_decode, n_settings);
        $display("data_bits from 0 to 63 with overall parity on and off.");
        if (mismatch_count == 0 && words_in_flight == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
